@@ src/maws_pkg.sv @@
`default_nettype none

package maws_pkg;

    localparam int MAX_VALUES = 4096;
    localparam int VALUE_BITS = 24;
    localparam int ADDR_W     = $clog2(MAX_VALUES);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int SUM_W      = 36;
    localparam int LEN_W      = 13;
    localparam int FIRST_W    = 24;
    localparam int PROD_W     = SUM_W + LEN_W;

    localparam logic [LEN_W-1:0] MIN_LEN_RESET = LEN_W'(50);

    typedef struct packed {
        logic [ADDR_W-1:0] hi_addr;
        logic [ADDR_W-1:0] lo_addr;
        logic [ADDR_W-1:0] first_addr;
    } t_rd_req;

    typedef struct packed {
        logic [SUM_W-1:0]      hi;
        logic [SUM_W-1:0]      lo;
        logic [VALUE_BITS-1:0] first;
    } t_rd_data;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             dropped;
    } t_store_stat;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [LEN_W-1:0]   len;
        logic [FIRST_W-1:0] first;
        logic               found;
        logic               overflow;
    } t_result;

endpackage

`default_nettype wire

@@ src/maws_store.sv @@
`default_nettype none

module maws_store (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_load,
    input  wire logic [maws_pkg::VALUE_BITS-1:0] i_value,
    input  wire logic                            i_clear,
    input  wire maws_pkg::t_rd_req               i_rd_req,
    output maws_pkg::t_rd_data                   o_rd_data,
    output maws_pkg::t_store_stat                o_stat
);

    // prefix entry k (k >= 1) lives at address k-1; entry zero is implied
    logic [maws_pkg::VALUE_BITS-1:0] r_val_mem [maws_pkg::MAX_VALUES];
    logic [maws_pkg::SUM_W-1:0]      r_pre_mem [maws_pkg::MAX_VALUES];

    logic [maws_pkg::CNT_W-1:0] r_count;
    logic                       r_dropped;
    logic [maws_pkg::SUM_W-1:0] r_run;
    logic [maws_pkg::SUM_W-1:0] w_run_next;
    logic                       w_full;
    logic                       w_wr;

    assign w_full     = (r_count == maws_pkg::CNT_W'(maws_pkg::MAX_VALUES));
    assign w_wr       = i_load && !w_full;
    assign w_run_next = r_run + maws_pkg::SUM_W'(i_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_run     <= '0;
        end else if (i_clear) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_run     <= '0;
        end else if (i_load) begin
            if (w_full) begin
                r_dropped <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
                r_run   <= w_run_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_val_mem[r_count[maws_pkg::ADDR_W-1:0]] <= i_value;
            r_pre_mem[r_count[maws_pkg::ADDR_W-1:0]] <= w_run_next;
        end
        o_rd_data.first <= r_val_mem[i_rd_req.first_addr];
        o_rd_data.hi    <= r_pre_mem[i_rd_req.hi_addr];
        o_rd_data.lo    <= r_pre_mem[i_rd_req.lo_addr];
    end

    assign o_stat.count   = r_count;
    assign o_stat.dropped = r_dropped;

endmodule

`default_nettype wire

@@ src/maws_seq.sv @@
`default_nettype none

module maws_seq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_go,
    input  wire logic [maws_pkg::LEN_W-1:0] i_min_len,
    input  wire maws_pkg::t_store_stat      i_stat,
    input  wire maws_pkg::t_rd_data         i_rd_data,
    output maws_pkg::t_rd_req               o_rd_req,
    output logic                            o_clear,
    output logic                            o_busy,
    output logic                            o_strobe,
    output maws_pkg::t_result               o_result
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_INIT = 8'b0000_0010,
        S_ADDR = 8'b0000_0100,
        S_DIFF = 8'b0000_1000,
        S_MUL1 = 8'b0001_0000,
        S_MUL2 = 8'b0010_0000,
        S_CMP  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [maws_pkg::LEN_W-1:0]      r_len, n_len;
    logic [maws_pkg::LEN_W-1:0]      r_end, n_end;
    logic [maws_pkg::ADDR_W-1:0]     r_start, n_start;
    logic [maws_pkg::SUM_W-1:0]      r_s, n_s;
    logic [maws_pkg::VALUE_BITS-1:0] r_first, n_first;
    logic [maws_pkg::PROD_W-1:0]     r_p1, n_p1;
    logic [maws_pkg::PROD_W-1:0]     r_p2, n_p2;
    logic [maws_pkg::SUM_W-1:0]      r_best_sum, n_best_sum;
    logic [maws_pkg::LEN_W-1:0]      r_best_len, n_best_len;
    logic [maws_pkg::VALUE_BITS-1:0] r_best_first, n_best_first;
    logic                            r_found, n_found;
    logic                            r_strobe, n_strobe;
    maws_pkg::t_result               r_result, n_result;

    logic [maws_pkg::LEN_W-1:0]  w_cnt;
    logic [maws_pkg::LEN_W-1:0]  w_min;
    logic [maws_pkg::SUM_W-1:0]  w_mul_a;
    logic [maws_pkg::LEN_W-1:0]  w_mul_b;
    logic [maws_pkg::PROD_W-1:0] w_prod;
    logic                        w_better;

    assign w_cnt = maws_pkg::LEN_W'(i_stat.count);
    assign w_min = (i_min_len == '0) ? maws_pkg::LEN_W'(1) : i_min_len;

    // shared multiplier: candidate sum * best length, then best sum * length
    assign w_mul_a = (r_state == S_MUL1) ? r_s : r_best_sum;
    assign w_mul_b = (r_state == S_MUL1) ? r_best_len : r_len;
    assign w_prod  = {{maws_pkg::LEN_W{1'b0}}, w_mul_a} *
                     {{maws_pkg::SUM_W{1'b0}}, w_mul_b};

    assign w_better = r_found ? (r_p1 > r_p2) : (r_s != '0);

    assign o_rd_req.hi_addr    = maws_pkg::ADDR_W'(r_end - 1'b1);
    assign o_rd_req.lo_addr    = r_start - 1'b1;
    assign o_rd_req.first_addr = r_start;

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_end        = r_end;
        n_start      = r_start;
        n_s          = r_s;
        n_first      = r_first;
        n_p1         = r_p1;
        n_p2         = r_p2;
        n_best_sum   = r_best_sum;
        n_best_len   = r_best_len;
        n_best_first = r_best_first;
        n_found      = r_found;
        n_result     = r_result;
        n_strobe     = 1'b0;
        o_clear      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_best_sum   = '0;
                n_best_len   = '0;
                n_best_first = '0;
                n_found      = 1'b0;
                n_len        = w_min;
                n_end        = w_min;
                n_start      = '0;
                n_state      = (w_min > w_cnt) ? S_FIN : S_ADDR;
            end
            S_ADDR: begin
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_s     = i_rd_data.hi - ((r_start == '0) ? '0 : i_rd_data.lo);
                n_first = i_rd_data.first;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_p1    = w_prod;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_p2    = w_prod;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_better) begin
                    n_best_sum   = r_s;
                    n_best_len   = r_len;
                    n_best_first = r_first;
                    n_found      = 1'b1;
                end
                if (r_end == w_cnt) begin
                    if (r_start == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_len   = r_len + 1'b1;
                        n_end   = r_len + 1'b1;
                        n_start = '0;
                        n_state = S_ADDR;
                    end
                end else begin
                    n_start = r_start + 1'b1;
                    n_end   = r_end + 1'b1;
                    n_state = S_ADDR;
                end
            end
            S_FIN: begin
                n_result.sum      = r_best_sum;
                n_result.len      = r_best_len;
                n_result.first    = maws_pkg::FIRST_W'(r_best_first);
                n_result.found    = r_found;
                n_result.overflow = i_stat.dropped;
                n_strobe          = 1'b1;
                o_clear           = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_end        <= n_end;
        r_start      <= n_start;
        r_s          <= n_s;
        r_first      <= n_first;
        r_p1         <= n_p1;
        r_p2         <= n_p2;
        r_best_sum   <= n_best_sum;
        r_best_len   <= n_best_len;
        r_best_first <= n_best_first;
        r_found      <= n_found;
        r_result     <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_FIN))
        else $error("result beat without a finishing step");

    a_window_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR) |->
            (r_len != '0) && (r_end <= w_cnt) &&
            (r_end == r_len + maws_pkg::LEN_W'(r_start)))
        else $error("window outside loaded sequence");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CMP) && r_found) |-> (r_best_len != '0) && (r_best_sum != '0))
        else $error("best window recorded without a positive sum");

endmodule

`default_nettype wire

@@ src/max_average_window_search_core.sv @@
// Channel   Direction  Handshake               Payload
// input     in         start & !busy           i_sample_value, i_is_last
// result    out        o_strobe (one cycle)    o_best_sum, o_best_length,
//                                              o_best_first_value, o_found, o_overflow
// config    in         i_cfg_valid & o_cfg_ready  i_cfg_data (min_window_length)
//
// Value beats are taken back to back; busy stays low while loading.
// A beat with i_is_last holds busy high through an init step, one pass per window searched
// (each window costs five steps of the one shared multiplier loop) and a finishing step.
// The result strobe is high in the first cycle that busy is low again.
// Reset clears the load count, drop flag and sequencer; min length resets to 50.
// The receiver cannot stall: each result is marked by o_strobe for exactly one cycle.
`default_nettype none

module max_average_window_search_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [maws_pkg::VALUE_BITS-1:0] i_sample_value,
    input  wire logic                            i_is_last,
    output logic                                 o_strobe,
    output logic [maws_pkg::SUM_W-1:0]           o_best_sum,
    output logic [maws_pkg::LEN_W-1:0]           o_best_length,
    output logic [maws_pkg::FIRST_W-1:0]         o_best_first_value,
    output logic                                 o_found,
    output logic                                 o_overflow,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [maws_pkg::LEN_W-1:0]      i_cfg_data
);

    logic [maws_pkg::LEN_W-1:0] r_min_len;
    logic                       w_busy;
    logic                       w_accept;
    logic                       w_clear;
    maws_pkg::t_rd_req          w_rd_req;
    maws_pkg::t_rd_data         w_rd_data;
    maws_pkg::t_store_stat      w_stat;
    maws_pkg::t_result          w_result;

    assign w_accept    = start && !w_busy;
    assign o_cfg_ready = !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= maws_pkg::MIN_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_len <= i_cfg_data;
        end
    end

    maws_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_accept),
        .i_value   (i_sample_value),
        .i_clear   (w_clear),
        .i_rd_req  (w_rd_req),
        .o_rd_data (w_rd_data),
        .o_stat    (w_stat)
    );

    maws_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_accept && i_is_last),
        .i_min_len (r_min_len),
        .i_stat    (w_stat),
        .i_rd_data (w_rd_data),
        .o_rd_req  (w_rd_req),
        .o_clear   (w_clear),
        .o_busy    (w_busy),
        .o_strobe  (o_strobe),
        .o_result  (w_result)
    );

    assign busy               = w_busy;
    assign o_best_sum         = w_result.sum;
    assign o_best_length      = w_result.len;
    assign o_best_first_value = w_result.first;
    assign o_found            = w_result.found;
    assign o_overflow         = w_result.overflow;

endmodule

`default_nettype wire
